>>> rtl/ektt_pkg.sv
// Shared types and constants of the expiring keyed target table.
package ektt_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int ID_W   = 32;
  localparam int TICK_W = 32;
  localparam int POS_W  = 24;
  localparam int RAD_W  = 23;
  localparam int SQ_W   = 2 * POS_W + 1;
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int DIST_W = SQ_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DURATION = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_CENTER_Z = 3'd3,
    REG_RADIUS   = 3'd4,
    REG_RESTRICT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_PURGE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [TICK_W-1:0]       tick;
    logic [ID_W-1:0]         key;
    logic [ID_W-1:0]         reporter;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } item_t;

  typedef struct packed {
    logic                    valid;
    logic [ID_W-1:0]         key;
    logic [ID_W-1:0]         reporter;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [TICK_W-1:0]       seen;
    logic [TICK_W-1:0]       expire;
    logic                    in_area;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] tick;
    logic              dropped;
  } stage_t;

  typedef struct packed {
    logic                    any_live;
    logic                    found;
    logic [ID_W-1:0]         player;
    logic [ID_W-1:0]         reporter;
    logic [TICK_W-1:0]       seen;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pick_t;

endpackage

>>> rtl/ektt_area.sv
// Sphere membership check; carries the item to the table stage.
module ektt_area import ektt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  item_t                   in_item,
  input  logic signed [POS_W-1:0] center_x,
  input  logic signed [POS_W-1:0] center_y,
  input  logic signed [POS_W-1:0] center_z,
  input  logic [RAD_W-1:0]        area_radius,
  output logic                    out_valid,
  output item_t                   out_item,
  output logic                    out_in_area
);

  logic                     valid1;
  logic                     valid2;
  item_t                    item1;
  item_t                    item2;
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_y;
  logic [SQ_W-1:0]          sq_z;
  logic [RSQ_W-1:0]         r_sq;
  logic signed [POS_W:0]    dx;
  logic signed [POS_W:0]    dy;
  logic signed [POS_W:0]    dz;
  logic signed [2*POS_W+1:0] px;
  logic signed [2*POS_W+1:0] py;
  logic signed [2*POS_W+1:0] pz;
  logic [RSQ_W-1:0]         pr;
  logic [DIST_W-1:0]        dist_sum;
  logic                     in_sphere;

  assign dx = {item1.x[POS_W-1], item1.x} - {center_x[POS_W-1], center_x};
  assign dy = {item1.y[POS_W-1], item1.y} - {center_y[POS_W-1], center_y};
  assign dz = {item1.z[POS_W-1], item1.z} - {center_z[POS_W-1], center_z};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;
  assign pr = RSQ_W'(area_radius) * RSQ_W'(area_radius);

  assign dist_sum  = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
  assign in_sphere = (dist_sum <= DIST_W'(r_sq));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid1    <= in_valid;
      valid2    <= valid1;
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item1       <= in_item;
      item2       <= item1;
      sq_x        <= px[SQ_W-1:0];
      sq_y        <= py[SQ_W-1:0];
      sq_z        <= pz[SQ_W-1:0];
      r_sq        <= pr;
      out_item    <= item2;
      out_in_area <= in_sphere;
    end
  end

endmodule

>>> rtl/ektt_slots.sv
// Slot storage: report, purge and clear updates, and the following stage register.
module ektt_slots import ektt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  item_t             in_item,
  input  logic              in_area,
  input  logic [TICK_W-1:0] memory_duration,
  output entry_t            entries [SLOT_COUNT],
  output stage_t            stage
);

  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] free;
  logic [SLOT_W-1:0]     match_idx;
  logic [SLOT_W-1:0]     free_idx;
  logic [SLOT_W-1:0]     sel;
  logic                  is_report;
  logic                  dropped;
  entry_t                fresh;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = entries[i].valid && (entries[i].key == in_item.key);
      free[i]  = !entries[i].valid;
    end
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (match[i]) match_idx = SLOT_W'(i);
      if (free[i])  free_idx  = SLOT_W'(i);
    end
  end

  assign sel       = (|match) ? match_idx : free_idx;
  assign is_report = (in_item.op == OP_REPORT);
  assign dropped   = is_report && !(|match) && !(|free);

  always_comb begin
    fresh.valid    = 1'b1;
    fresh.key      = in_item.key;
    fresh.reporter = in_item.reporter;
    fresh.x        = in_item.x;
    fresh.y        = in_item.y;
    fresh.z        = in_item.z;
    fresh.seen     = in_item.tick;
    fresh.expire   = in_item.tick + memory_duration;
    fresh.in_area  = in_area;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        entries[i].valid <= 1'b0;
      end
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage.valid   <= in_valid;
      stage.tick    <= in_item.tick;
      stage.dropped <= in_valid && dropped;
      if (in_valid) begin
        case (in_item.op)
          OP_REPORT: begin
            if (!dropped) begin
              entries[sel] <= fresh;
            end
          end
          OP_PURGE: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (entries[i].valid && (in_item.tick > entries[i].expire)) begin
                entries[i].valid <= 1'b0;
              end
            end
          end
          OP_CLEAR: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              entries[i].valid <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/ektt_pick.sv
// Liveness test and latest-sighting selection over all slots.
module ektt_pick import ektt_pkg::*; (
  input  entry_t            entries [SLOT_COUNT],
  input  logic [TICK_W-1:0] tick,
  input  logic              area_restrict,
  output pick_t             result
);

  logic [SLOT_COUNT-1:0] live;
  logic [SLOT_COUNT-1:0] cand;
  logic [SLOT_COUNT-1:0] is_best;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      live[i] = entries[i].valid && !(tick > entries[i].expire);
      cand[i] = live[i] && (!area_restrict || entries[i].in_area);
    end
  end

  // ties go to the lower slot
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      is_best[i] = cand[i];
      for (int j = 0; j < SLOT_COUNT; j++) begin
        if (j < i) begin
          if (cand[j] && !(entries[i].seen > entries[j].seen)) is_best[i] = 1'b0;
        end else if (j > i) begin
          if (cand[j] && (entries[i].seen < entries[j].seen)) is_best[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    result          = '0;
    result.any_live = |live;
    result.found    = |cand;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (is_best[i]) begin
        result.player   = result.player   | entries[i].key;
        result.reporter = result.reporter | entries[i].reporter;
        result.seen     = result.seen     | entries[i].seen;
        result.x        = result.x        | entries[i].x;
        result.y        = result.y        | entries[i].y;
        result.z        = result.z        | entries[i].z;
      end
    end
  end

endmodule

>>> rtl/expiring_keyed_target_table.sv
// Top level of the expiring keyed target table.
// Input channel: op, current_tick, player_id, reporter_id and pos_x/y/z move
// on a transfer (in_valid high, in_stall low). Every item yields exactly one
// result on the output channel (out_valid / out_stall).
// Configuration: cfg_wr_en writes cfg_data into the register chosen by
// cfg_index; write only while no item is in flight.
// Path: an input transfer passes the sphere check's registers (input, squares,
// then sum and compare), then the slot update stage register, then the
// selection into the output register, where its result is presented.
// Throughput: one item per cycle while the output is not stalled; the stages advance together.
// Stall: while the output register holds a result that is stalled, the whole
// pipeline holds and in_stall is raised; nothing is lost or repeated.
// Reset: clears all configuration registers, empties every slot and drops
// any items in flight.
module expiring_keyed_target_table import ektt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              op,
  input  logic [TICK_W-1:0]       current_tick,
  input  logic [ID_W-1:0]         player_id,
  input  logic [ID_W-1:0]         reporter_id,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    any_live,
  output logic                    best_found,
  output logic [ID_W-1:0]         best_player,
  output logic [ID_W-1:0]         best_reporter,
  output logic [TICK_W-1:0]       best_seen_tick,
  output logic signed [POS_W-1:0] best_x,
  output logic signed [POS_W-1:0] best_y,
  output logic signed [POS_W-1:0] best_z,
  output logic                    report_dropped,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [TICK_W-1:0]       memory_duration;
  logic signed [POS_W-1:0] center_x;
  logic signed [POS_W-1:0] center_y;
  logic signed [POS_W-1:0] center_z;
  logic [RAD_W-1:0]        area_radius;
  logic                    area_restrict;

  logic   advance;
  item_t  in_item;
  logic   area_valid;
  item_t  area_item;
  logic   area_in;
  entry_t entries [SLOT_COUNT];
  stage_t stage;
  pick_t  pick;
  logic [SLOT_COUNT-1:0] valid_bits;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_comb begin
    in_item.op       = op;
    in_item.tick     = current_tick;
    in_item.key      = player_id;
    in_item.reporter = reporter_id;
    in_item.x        = pos_x;
    in_item.y        = pos_y;
    in_item.z        = pos_z;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      valid_bits[i] = entries[i].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_duration <= '0;
      center_x        <= '0;
      center_y        <= '0;
      center_z        <= '0;
      area_radius     <= '0;
      area_restrict   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DURATION: memory_duration <= cfg_data[TICK_W-1:0];
        REG_CENTER_X: center_x        <= cfg_data[POS_W-1:0];
        REG_CENTER_Y: center_y        <= cfg_data[POS_W-1:0];
        REG_CENTER_Z: center_z        <= cfg_data[POS_W-1:0];
        REG_RADIUS:   area_radius     <= cfg_data[RAD_W-1:0];
        REG_RESTRICT: area_restrict   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ektt_area u_area (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .center_x    (center_x),
    .center_y    (center_y),
    .center_z    (center_z),
    .area_radius (area_radius),
    .out_valid   (area_valid),
    .out_item    (area_item),
    .out_in_area (area_in)
  );

  ektt_slots u_slots (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .in_valid        (area_valid),
    .in_item         (area_item),
    .in_area         (area_in),
    .memory_duration (memory_duration),
    .entries         (entries),
    .stage           (stage)
  );

  ektt_pick u_pick (
    .entries       (entries),
    .tick          (stage.tick),
    .area_restrict (area_restrict),
    .result        (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      any_live       <= pick.any_live;
      best_found     <= pick.found;
      best_player    <= pick.player;
      best_reporter  <= pick.reporter;
      best_seen_tick <= pick.seen;
      best_x         <= pick.x;
      best_y         <= pick.y;
      best_z         <= pick.z;
      report_dropped <= stage.dropped;
    end
  end

  a_found_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && best_found |-> any_live)
    else $error("best entry reported with no live entry");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !best_found |-> (best_player == '0) && (best_reporter == '0))
    else $error("best fields not zero when no entry found");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    stage.valid && stage.dropped |-> (&valid_bits))
    else $error("report dropped while a slot was free");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && (valid_bits == '0))
    else $error("result or slot survived reset");

endmodule
